FILE: hdl/histogram_peak_three_level_classifier_defines.svh
// ----------------------------------------------------------------------------
// Histogram peak classifier assertion macros
// Shared property forms for the concurrent checks of the classifier.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_PEAK_THREE_LEVEL_CLASSIFIER_DEFINES_SVH
`define HISTOGRAM_PEAK_THREE_LEVEL_CLASSIFIER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define HPC_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define HPC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hpc_pkg.sv
// ----------------------------------------------------------------------------
// Histogram peak classifier package
// Shared constants, sequencer states, level codes and histogram control.
// ----------------------------------------------------------------------------
`default_nettype none

package hpc_pkg;

  localparam int BUCKETS_DEF    = 128;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SAMPLE_W       = 10;
  localparam int OUT_BKT_W      = 7;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 10'd900;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_INC,
    ST_SCAN,
    ST_PASS,
    ST_ZERO,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    LVL_BLACK = 2'd0,
    LVL_GREY  = 2'd1,
    LVL_WHITE = 2'd2
  } level_t;

  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } hist_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/histogram_peak_three_level_classifier.sv
// ----------------------------------------------------------------------------
// Histogram peak three-level classifier
// Each sample is bucketed and counted; the three highest histogram peaks set
// black/grey/white thresholds and the sample's bucket is classified.
//
// Input channel in_valid/in_ready carries sample_value and restart; restart
// clears the histogram before the sample is counted. Output channel
// out_valid/out_ready carries level_class, bucket, thresh_upper, thresh_lower.
// full_scale is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. The
// sequencer runs the bit-serial divider, the one-read-per-cycle peak scan of
// the count memory and three argmax passes over the peak list memory.
// in_ready is high only in idle. A result sits in an output register, so a
// new sample transfers while the previous result waits; if the result is
// still not taken when the next one finishes, the sequencer holds.
// Reset clears all counts, loads full_scale with 900 and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_peak_three_level_classifier #(
  parameter int BUCKETS    = hpc_pkg::BUCKETS_DEF,
  parameter int COUNT_BITS = hpc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hpc_pkg::SAMPLE_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hpc_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    level_class,
  output logic [hpc_pkg::OUT_BKT_W-1:0] bucket,
  output logic [hpc_pkg::OUT_BKT_W-1:0] thresh_upper,
  output logic [hpc_pkg::OUT_BKT_W-1:0] thresh_lower
);
  import hpc_pkg::*;

  localparam int BW    = $clog2(BUCKETS);
  localparam int SLOTS = BUCKETS / 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int NSW   = $clog2(SLOTS + 1);
  localparam int SCW   = $clog2(BUCKETS + 2);
  localparam int NW    = SAMPLE_W + BW + 1;
  localparam int EW    = BW + COUNT_BITS;

  state_t state, state_next;

  logic [SAMPLE_W-1:0]   full_scale;
  logic [BW-1:0]         bkt;
  logic [SCW-1:0]        scnt;
  logic [COUNT_BITS-1:0] prev_c, cur_c, h0, right_c;
  logic [NSW-1:0]        nslots, pcnt;
  logic [1:0]            pass_idx;
  logic [BW-1:0]         best_b, m1, m2, m3;
  logic [COUNT_BITS-1:0] best_c;
  logic [SW-1:0]         best_at;

  logic [EW-1:0]         slot_mem [SLOTS];
  logic [EW-1:0]         slot_rd;
  logic                  slot_live;
  logic                  slot_we;
  logic [SW-1:0]         slot_wa;
  logic [EW-1:0]         slot_wd;
  logic [BW-1:0]         ent_b;
  logic [COUNT_BITS-1:0] ent_c;

  hist_ctl_t             hctl;
  logic [BW-1:0]         h_rd_addr;
  logic [COUNT_BITS-1:0] h_wr_data, h_rd_data;

  logic                  xfer_in, div_done, peak, load_out;
  logic [NW-1:0]         div_num, div_q;

  logic [BW-1:0]         mx_ab, mn_ab, white, black, grey;
  logic [BW:0]           sum_up, sum_lo;
  logic [BW-1:0]         thr_up, thr_lo;
  level_t                lvl;

  assign in_ready = (state == ST_IDLE);
  assign xfer_in  = in_valid && in_ready;
  assign div_num  = NW'(sample_value) * NW'(BUCKETS);

  hpc_div #(
    .NW (NW),
    .DW (SAMPLE_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (xfer_in),
    .num   (div_num),
    .den   (full_scale),
    .done  (div_done),
    .quot  (div_q)
  );

  hpc_hist #(
    .BUCKETS    (BUCKETS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .rd_addr (h_rd_addr),
    .wr_addr (bkt),
    .wr_data (h_wr_data),
    .rd_data (h_rd_data)
  );

  always_comb begin
    right_c = (scnt == SCW'(BUCKETS + 1)) ? '0 : h_rd_data;
    peak    = (prev_c < cur_c) && (cur_c > right_c);
    ent_b   = slot_live ? slot_rd[EW-1:COUNT_BITS] : '0;
    ent_c   = slot_live ? slot_rd[COUNT_BITS-1:0] : h0;

    h_wr_data = (h_rd_data == '1) ? h_rd_data : h_rd_data + 1'b1;
    h_rd_addr = (state == ST_READ) ? bkt : scnt[BW-1:0];
    hctl.clear = xfer_in && restart;
    hctl.rd    = (state == ST_READ) || ((state == ST_SCAN) && (scnt < SCW'(BUCKETS)));
    hctl.wr    = (state == ST_INC);

    slot_we = 1'b0;
    slot_wa = best_at;
    slot_wd = {{BW{1'b0}}, h0};
    if (state == ST_SCAN) begin
      slot_wa = nslots[SW-1:0];
      slot_wd = {BW'(scnt - SCW'(2)), cur_c};
      slot_we = (scnt >= SCW'(3)) && peak && (nslots < NSW'(SLOTS));
    end else if (state == ST_ZERO) begin
      slot_we = 1'b1;
    end
  end

  always_comb begin
    mx_ab  = (m1 > m2) ? m1 : m2;
    mn_ab  = (m1 > m2) ? m2 : m1;
    white  = (m3 > mx_ab) ? m3 : mx_ab;
    black  = (m3 < mn_ab) ? m3 : mn_ab;
    grey   = (m3 > mx_ab) ? mx_ab : ((m3 < mn_ab) ? mn_ab : m3);
    sum_up = {1'b0, white} + {1'b0, grey};
    sum_lo = {1'b0, black} + {1'b0, grey};
    thr_up = sum_up[BW:1];
    thr_lo = sum_lo[BW:1];
    priority if (bkt < thr_lo) begin
      lvl = LVL_BLACK;
    end else if (bkt < thr_up) begin
      lvl = LVL_GREY;
    end else begin
      lvl = LVL_WHITE;
    end
  end

  assign load_out = (state == ST_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (xfer_in) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_READ;
      ST_READ: state_next = ST_INC;
      ST_INC:  state_next = ST_SCAN;
      ST_SCAN: if (scnt == SCW'(BUCKETS + 1)) state_next = ST_PASS;
      ST_PASS: if (pcnt == NSW'(SLOTS)) state_next = ST_ZERO;
      ST_ZERO: state_next = (pass_idx == 2'd2) ? ST_FIN : ST_PASS;
      ST_FIN:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        full_scale <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if ((state == ST_PASS) && (pcnt < NSW'(SLOTS))) begin
      slot_rd   <= slot_mem[pcnt[SW-1:0]];
      slot_live <= pcnt < nslots;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_DIV: begin
        if (div_done) begin
          bkt <= (div_q > NW'(BUCKETS - 1)) ? BW'(BUCKETS - 1) : div_q[BW-1:0];
        end
      end
      ST_INC: begin
        scnt   <= '0;
        nslots <= '0;
      end
      ST_SCAN: begin
        scnt <= scnt + 1'b1;
        if ((scnt >= SCW'(1)) && (scnt <= SCW'(BUCKETS))) begin
          prev_c <= cur_c;
          cur_c  <= h_rd_data;
        end
        if (scnt == SCW'(1)) begin
          h0 <= h_rd_data;
        end
        if (slot_we) begin
          nslots <= nslots + 1'b1;
        end
        pcnt     <= '0;
        pass_idx <= '0;
      end
      ST_PASS: begin
        pcnt <= pcnt + 1'b1;
        if (pcnt >= NSW'(1)) begin
          if ((pcnt == NSW'(1)) || (ent_c > best_c)) begin
            best_b  <= ent_b;
            best_c  <= ent_c;
            best_at <= SW'(pcnt - 1'b1);
          end
        end
      end
      ST_ZERO: begin
        pcnt     <= '0;
        pass_idx <= pass_idx + 1'b1;
        unique case (pass_idx)
          2'd0:    m1 <= best_b;
          2'd1:    m2 <= best_b;
          default: m3 <= best_b;
        endcase
      end
      ST_FIN: begin
        if (load_out) begin
          level_class  <= lvl;
          bucket       <= OUT_BKT_W'(bkt);
          thresh_upper <= OUT_BKT_W'(thr_up);
          thresh_lower <= OUT_BKT_W'(thr_lo);
        end
      end
      default: begin
      end
    endcase
  end

`include "histogram_peak_three_level_classifier_defines.svh"

  `HPC_AST_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "ready after transfer")
  `HPC_AST_SAME(a_class_code, out_valid, (level_class == LVL_BLACK) || (level_class == LVL_GREY) || (level_class == LVL_WHITE), "bad level code")
  `HPC_AST_SAME(a_slot_bound, state == ST_SCAN, nslots <= NSW'(SLOTS), "peak list overflow")
  `HPC_AST_SAME(a_thresh_order, state == ST_FIN, thr_lo <= thr_up, "thresholds out of order")

endmodule

`default_nettype wire

FILE: hdl/hpc_div.sv
// ----------------------------------------------------------------------------
// Histogram peak classifier divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_div #(
  parameter int NW = 18,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, q[NW-1]};
  assign fits  = trial >= {1'b0, den};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
    end else if (run) begin
      rem <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      q   <= {q[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpc_hist.sv
// ----------------------------------------------------------------------------
// Histogram peak classifier count store
// Count memory with per-entry valid bits; invalid entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_hist #(
  parameter int BUCKETS    = 128,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hpc_pkg::hist_ctl_t         ctl,
  input  logic [$clog2(BUCKETS)-1:0] rd_addr,
  input  logic [$clog2(BUCKETS)-1:0] wr_addr,
  input  logic [COUNT_BITS-1:0]      wr_data,
  output logic [COUNT_BITS-1:0]      rd_data
);
  import hpc_pkg::*;

  logic [COUNT_BITS-1:0] mem [BUCKETS];
  logic [BUCKETS-1:0]    valid;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  rd_vld;

  assign rd_data = rd_vld ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (ctl.rd) begin
      rd_vld <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_histogram_peak_three_level_classifier.sv
// ----------------------------------------------------------------------------
// Histogram peak classifier testbench
// Drives samples with random restarts and full-scale settings through the
// valid/ready channels, predicts each bucket, threshold pair and level from a
// model of the count histogram, and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

class level_scoreboard;
  int unsigned counts[128];
  int unsigned scale;
  hpc_pkg::level_t lvl_q[$];
  bit [6:0] bkt_q[$];
  bit [6:0] up_q[$];
  bit [6:0] lo_q[$];
  int errors;
  int matched;

  function void clear_all();
    foreach (counts[i]) counts[i] = 0;
    scale = 900;
  endfunction

  function int unsigned pick_peak(ref int unsigned slots[64]);
    int unsigned best;
    int unsigned at;
    best = slots[0];
    at = 0;
    for (int i = 1; i < 64; i++) begin
      if (counts[slots[i]] > counts[best]) begin
        best = slots[i];
        at = i;
      end
    end
    slots[at] = 0;
    return best;
  endfunction

  function void note_sample(bit [9:0] v, bit rs);
    int unsigned slots[64];
    int unsigned n, b, m1, m2, m3, wh, bl, gr, up, lo, right;
    hpc_pkg::level_t lv;
    if (rs) foreach (counts[i]) counts[i] = 0;
    if (scale == 0) b = 127;
    else begin
      b = (v * 128) / scale;
      if (b > 127) b = 127;
    end
    if (counts[b] < 65535) counts[b]++;
    foreach (slots[i]) slots[i] = 0;
    n = 0;
    for (int i = 1; i < 128; i++) begin
      right = (i < 127) ? counts[i+1] : 0;
      if (counts[i-1] < counts[i] && counts[i] > right && n < 64) begin
        slots[n] = i;
        n++;
      end
    end
    m1 = pick_peak(slots);
    m2 = pick_peak(slots);
    m3 = pick_peak(slots);
    wh = m1; if (m2 > wh) wh = m2; if (m3 > wh) wh = m3;
    bl = m1; if (m2 < bl) bl = m2; if (m3 < bl) bl = m3;
    gr = m1 + m2 + m3 - wh - bl;
    up = (wh + gr) / 2;
    lo = (bl + gr) / 2;
    if (b < lo) lv = hpc_pkg::LVL_BLACK;
    else if (b < up) lv = hpc_pkg::LVL_GREY;
    else lv = hpc_pkg::LVL_WHITE;
    lvl_q.push_back(lv);
    bkt_q.push_back(b[6:0]);
    up_q.push_back(up[6:0]);
    lo_q.push_back(lo[6:0]);
  endfunction

  function void check_result(bit [1:0] lv, bit [6:0] b, bit [6:0] up, bit [6:0] lo);
    if (lvl_q.size() == 0) begin
      $display("%0t: unexpected result class=%0d bucket=%0d", $time, lv, b);
      errors++;
      return;
    end
    if (lv !== lvl_q[0]) begin
      $display("%0t: level_class expected %0d actual %0d", $time, lvl_q[0], lv);
      errors++;
    end
    if (b !== bkt_q[0]) begin
      $display("%0t: bucket expected %0d actual %0d", $time, bkt_q[0], b);
      errors++;
    end
    if (up !== up_q[0]) begin
      $display("%0t: thresh_upper expected %0d actual %0d", $time, up_q[0], up);
      errors++;
    end
    if (lo !== lo_q[0]) begin
      $display("%0t: thresh_lower expected %0d actual %0d", $time, lo_q[0], lo);
      errors++;
    end
    void'(lvl_q.pop_front());
    void'(bkt_q.pop_front());
    void'(up_q.pop_front());
    void'(lo_q.pop_front());
    matched++;
  endfunction

  function int pending();
    return lvl_q.size();
  endfunction
endclass

module tb_histogram_peak_three_level_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] sample_value = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] level_class;
  logic [6:0] bucket;
  logic [6:0] thresh_upper;
  logic [6:0] thresh_lower;

  level_scoreboard sb;
  int unsigned cycles = 0;
  int sent = 0;
  int restarts = 0;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  always #6 clk = ~clk;

  histogram_peak_three_level_classifier uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
    .restart(restart), .out_valid(out_valid), .out_ready(out_ready),
    .level_class(level_class), .bucket(bucket), .thresh_upper(thresh_upper),
    .thresh_lower(thresh_lower)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high after a transfer until the next gap or a drain
  task automatic send_sample(bit [9:0] v, bit rs);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(v, rs);
    sent++;
    if (rs) restarts++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_scale(bit [9:0] fs);
    cfg_we <= 1'b1;
    cfg_wdata <= fs;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.scale = fs;
  endtask

  // take results with random stalls
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(level_class, bucket, thresh_upper, thresh_lower);
    end
  end

  initial begin
    bit [9:0] scales[6];
    bit [9:0] centers[3];
    sb = new();
    sb.clear_all();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, restart, peaks at the top bucket
    send_sample(10'd0, 1'b1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd899, 1'b0);
    send_sample(10'd450, 1'b0);
    send_sample(10'd450, 1'b0);
    send_sample(10'h155, 1'b0);
    send_sample(10'h2AA, 1'b0);
    send_sample(10'd7, 1'b1);
    drain();
    write_scale(10'd0);
    send_sample(10'd5, 1'b0);
    send_sample(10'd1023, 1'b1);
    drain();
    write_scale(10'd1);
    send_sample(10'd0, 1'b1);
    send_sample(10'd1, 1'b0);
    send_sample(10'd1023, 1'b0);
    drain();
    write_scale(10'd1023);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd512, 1'b0);
    send_sample(10'd100, 1'b0);
    drain();

    // random phases: three clustered levels plus noise
    scales = '{10'd900, 10'd1023, 10'd1, 10'd0, 10'd300, 10'd700};
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(ph < 2 ? scales[ph] : ($urandom_range(0, 4) == 0 ?
                  scales[ph] : 10'($urandom_range(1, 1023))));
      for (int k = 0; k < 3; k++) centers[k] = 10'($urandom_range(0, 1023));
      for (int i = 0; i < 170; i++) begin
        bit [9:0] v;
        if ($urandom_range(0, 9) < 8)
          v = 10'(int'(centers[$urandom_range(0, 2)]) + $urandom_range(0, 40) - 20);
        else
          v = 10'($urandom);
        send_sample(v, ($urandom_range(0, 99) == 0) || i == 0);
        if (i == 85) drain();
      end
      drain();
    end

    // repeated samples in one bucket
    write_scale(10'd900);
    send_sample(10'd100, 1'b1);
    for (int i = 0; i < 6; i++) send_sample(10'd100, 1'b0);
    drain();

    $display("covered %0d samples, %0d with restart, %0d results checked",
             sent, restarts, sb.matched);
    $display("full_scale set to zero, one, max and random values");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
